// ----- design/shi_pkg.sv -----
// Shared types and constants for the string hash index block.
// Used by shi_mix, shi_fold and string_hash_index; no dependencies.
package shi_pkg;

	localparam int CHAR_W         = 8;
	localparam int ACC_W          = 32;
	localparam int HASH_W         = 31;
	localparam int SLOT_W         = 16;
	localparam int IDX_CFG_W      = 5;
	localparam int MAX_INDEX_BITS = 16;
	localparam int M_TDATA_W      = 48;

	localparam logic [IDX_CFG_W-1:0] INDEX_BITS_RESET = 5'd6;

	// mix selected by the running phase
	localparam logic [1:0] PH_ADD   = 2'd0;
	localparam logic [1:0] PH_XSUM  = 2'd1;
	localparam logic [1:0] PH_XOR   = 2'd2;
	localparam logic [1:0] PH_SUB   = 2'd3;

	typedef struct packed {
		logic [HASH_W-1:0] folded_hash;
		logic [SLOT_W-1:0] slot_index;
	} result_t;

endpackage

// ----- design/shi_mix.sv -----
// One-character accumulator mix for the string hash index block.
// Depends on shi_pkg for widths and phase codes.
module shi_mix (
	input  logic [shi_pkg::ACC_W-1:0]  acc,
	input  logic [shi_pkg::CHAR_W-1:0] char_value,
	input  logic [1:0]                 phase,
	output logic [shi_pkg::ACC_W-1:0]  acc_next
);
	import shi_pkg::*;

	logic [ACC_W-1:0] c;
	logic [ACC_W-1:0] c_asr;

	assign c     = {{(ACC_W-CHAR_W){char_value[CHAR_W-1]}}, char_value};
	assign c_asr = {c[ACC_W-1], c[ACC_W-1:1]};

	always_comb begin
		unique case (phase)
			PH_ADD:  acc_next = acc + ((c << 17) ^ (c << 11) ^ (c << 5) ^ c_asr);
			PH_XSUM: acc_next = acc ^ ((c << 14) + (c << 7) + (c << 4) + c);
			PH_XOR:  acc_next = acc ^ (((~c) << 11) | ((c << 3) ^ c_asr));
			PH_SUB:  acc_next = acc - ((c << 16) | (c << 9) | (c << 2)
					| {{(ACC_W-2){1'b0}}, c[1:0]});
			default: acc_next = acc;
		endcase
	end

endmodule

// ----- design/shi_fold.sv -----
// Fold of the accumulator to a nonnegative hash and masking to a table slot.
// Depends on shi_pkg for widths and the result struct.
module shi_fold (
	input  logic [shi_pkg::ACC_W-1:0]     acc,
	input  logic [shi_pkg::IDX_CFG_W-1:0] index_bits,
	output shi_pkg::result_t              result
);
	import shi_pkg::*;

	logic [HASH_W-1:0]    folded;
	logic [IDX_CFG_W-1:0] bits;
	logic [SLOT_W-1:0]    mask;

	assign folded = acc[ACC_W-1] ? ~acc[HASH_W-1:0] : acc[HASH_W-1:0];

	// clamp the width to 1..MAX_INDEX_BITS
	always_comb begin
		priority if (index_bits == '0)
			bits = IDX_CFG_W'(1);
		else if (index_bits > IDX_CFG_W'(MAX_INDEX_BITS))
			bits = IDX_CFG_W'(MAX_INDEX_BITS);
		else
			bits = index_bits;
	end

	always_comb begin
		for (int i = 0; i < SLOT_W; i++) begin
			mask[i] = (IDX_CFG_W'(i) < bits);
		end
	end

	assign result.folded_hash = folded;
	assign result.slot_index  = folded[SLOT_W-1:0] & mask;

endmodule

// ----- design/string_hash_index.sv -----
// Top level of the string hash index block: input register, accumulator and result register.
// Depends on shi_pkg, shi_mix and shi_fold.
//
// Usage: a name streams in one character per beat on the s_ channel
// (s_tdata[7:0] = char_value, signed). Nonzero characters fold into a
// 32-bit accumulator; a zero character ends the name and yields one result
// beat on the m_ channel carrying slot_index and folded_hash.
// Configuration: cfg_wen with cfg_wdata writes index_bits (log2 of the table
// size); write it only while no name is in flight.
// Throughput: one character per cycle, set by the combinational mix on the
// accumulator register, except while a terminator waits on a held result.
// The terminating zero passes the input register, then the result register,
// before m_tvalid rises.
// Reset: arst_n clears the accumulator, phase and valid flags and sets
// index_bits to 6.
// Stall: while a result waits on m_tready, nonzero characters keep flowing
// into the accumulator; a second terminator holds in the input register and
// s_tready drops until the waiting result is taken.
module string_hash_index (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] char_value
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [shi_pkg::M_TDATA_W-1:0]     m_tdata,   // [15:0] slot_index, [46:16] folded_hash, [47] zero
	input  logic                              cfg_wen,
	input  logic [shi_pkg::IDX_CFG_W-1:0]     cfg_wdata
);
	import shi_pkg::*;

	logic                 valid_s1;
	logic [CHAR_W-1:0]    char_s1;
	logic [ACC_W-1:0]     acc_q;
	logic [1:0]           phase_q;
	logic [IDX_CFG_W-1:0] index_bits_q;
	logic                 m_valid_q;
	result_t              result_q;

	logic                 is_term;
	logic                 out_free;
	logic                 advance_s1;
	logic [ACC_W-1:0]     acc_mixed;
	result_t              result_d;

	assign is_term    = (char_s1 == '0);
	assign out_free   = !m_valid_q || m_tready;
	assign advance_s1 = valid_s1 && (!is_term || out_free);
	assign s_tready   = !valid_s1 || advance_s1;

	shi_mix u_mix (
		.acc        (acc_q),
		.char_value (char_s1),
		.phase      (phase_q),
		.acc_next   (acc_mixed)
	);

	shi_fold u_fold (
		.acc        (acc_q),
		.index_bits (index_bits_q),
		.result     (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= INDEX_BITS_RESET;
		end else if (cfg_wen) begin
			index_bits_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			phase_q <= PH_ADD;
		end else if (advance_s1) begin
			if (is_term) begin
				acc_q   <= '0;
				phase_q <= PH_ADD;
			end else begin
				acc_q   <= acc_mixed;
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= advance_s1 && is_term;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && is_term) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, result_q.folded_hash, result_q.slot_index};

`ifndef SYNTHESIS
	// a terminator clears the running state
	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && is_term) |=> (acc_q == '0 && phase_q == PH_ADD))
		else $error("accumulator not cleared after terminator");

	// each nonzero character steps the phase once
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && !is_term) |=> (phase_q == $past(phase_q) + 2'd1))
		else $error("phase did not advance on character");

	// the slot never has bits the hash lacks
	a_slot_subset: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> ((result_q.slot_index & ~result_q.folded_hash[SLOT_W-1:0]) == '0))
		else $error("slot index not a masked hash");

	// a terminator waiting on a full output register holds off input
	a_term_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_term && m_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while terminator blocked");
`endif

endmodule

// ----- test/tb_string_hash_index.sv -----
// Self-checking testbench for string_hash_index: streams names, predicts slots.
// Depends on shi_pkg and the string_hash_index RTL; no files or arguments.
`timescale 1ns / 1ps

module tb_string_hash_index;
	import shi_pkg::*;

	// Running hash of the current name, plus the slot results still owed by the block.
	class slot_scoreboard;
		logic [ACC_W-1:0]     acc;
		logic [1:0]           phase;
		logic [IDX_CFG_W-1:0] index_bits;
		result_t              pending[$];
		int                   errors;
		int                   chars;
		int                   names;
		int                   checked;

		function new();
			acc        = '0;
			phase      = PH_ADD;
			index_bits = INDEX_BITS_RESET;
			errors     = 0;
			chars      = 0;
			names      = 0;
			checked    = 0;
		endfunction

		// Fold one accepted character into the hash; a zero ends the name.
		function void note_char(logic [CHAR_W-1:0] ch);
			logic [ACC_W-1:0] c;
			logic [ACC_W-1:0] half;
			logic [ACC_W-1:0] folded;
			logic [ACC_W-1:0] mask;
			int               w;
			result_t          r;
			c    = {{(ACC_W-CHAR_W){ch[CHAR_W-1]}}, ch};
			half = {c[ACC_W-1], c[ACC_W-1:1]};
			chars++;
			if (ch != '0) begin
				case (phase)
					PH_ADD:  acc = acc + ((c << 17) ^ (c << 11) ^ (c << 5) ^ half);
					PH_XSUM: acc = acc ^ ((c << 14) + (c << 7) + (c << 4) + c);
					PH_XOR:  acc = acc ^ (((~c) << 11) | ((c << 3) ^ half));
					default: acc = acc - ((c << 16) | (c << 9) | (c << 2) | (c & 32'd3));
				endcase
				phase = phase + 2'd1;
				return;
			end
			folded = acc[ACC_W-1] ? ~acc : acc;
			w = index_bits;
			if (w < 1)
				w = 1;
			if (w > MAX_INDEX_BITS)
				w = MAX_INDEX_BITS;
			mask = (32'd1 << w) - 32'd1;
			r.folded_hash = folded[HASH_W-1:0];
			r.slot_index  = folded[SLOT_W-1:0] & mask[SLOT_W-1:0];
			pending.push_back(r);
			names++;
			acc   = '0;
			phase = PH_ADD;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_result(logic [M_TDATA_W-1:0] beat);
			result_t want;
			if (pending.size() == 0) begin
				report($sformatf("result beat %h with nothing pending", beat));
				return;
			end
			want = pending.pop_front();
			checked++;
			if (beat[SLOT_W-1:0] !== want.slot_index)
				report($sformatf("slot_index %h, want %h", beat[SLOT_W-1:0], want.slot_index));
			if (beat[SLOT_W +: HASH_W] !== want.folded_hash)
				report($sformatf("folded_hash %h, want %h", beat[SLOT_W +: HASH_W],
					want.folded_hash));
			if (beat[M_TDATA_W-1] !== 1'b0)
				report("pad bit of result beat is set");
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;    // [7:0] char_value
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;    // [15:0] slot_index, [46:16] folded_hash, [47] zero
	logic                   cfg_wen;
	logic [IDX_CFG_W-1:0]   cfg_wdata;

	slot_scoreboard sb;

	string_hash_index u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results pending", sb.pending.size());
		$display("TB_ERROR");
		$finish;
	end

	// Send one character; keep tvalid high across back-to-back beats.
	task send_char(input logic [7:0] ch, input bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		do @(posedge clk); while (!s_tready);
		sb.note_char(ch);
	endtask

	function logic [7:0] pick_char();
		logic [7:0] ch;
		case ($urandom_range(0, 11))
			0:       ch = 8'h80;
			1:       ch = 8'h7f;
			2:       ch = 8'hff;
			3:       ch = 8'h01;
			default: ch = 8'($urandom_range(1, 255));
		endcase
		return ch;
	endfunction

	task send_name(input int len, input bit burst);
		for (int i = 0; i < len; i++)
			send_char(pick_char(), burst);
		send_char(8'h00, burst);
	endtask

	// Hold off the sender until every pending result has come back.
	task drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_index_bits(input logic [IDX_CFG_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.index_bits = value;
	endtask

	// Result side: random stalls, with stretches of steady tready.
	initial begin
		int gap;
		bit steady;
		steady = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 15) == 0)
				steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		logic [7:0]           directed [23];
		logic [IDX_CFG_W-1:0] widths [8];
		int                   target;
		int                   len;
		bit                   burst;
		sb = new();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_wen   <= 1'b0;
		cfg_wdata <= '0;
		// empty name, single extremes, one full round of mixes on extremes
		directed = '{8'h00, 8'h7f, 8'h00, 8'h80, 8'h00,
			8'hff, 8'hff, 8'hff, 8'hff, 8'h00,
			8'h80, 8'h80, 8'h80, 8'h80, 8'h00,
			8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h00,
			8'h01, 8'h00};
		widths = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd15,
			5'($urandom_range(2, 14)), 5'($urandom_range(18, 30))};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_char(directed[i], i > 10);
		drain_results();

		target = sb.chars;
		foreach (widths[k]) begin
			write_index_bits(widths[k]);
			target += 144;
			while (sb.chars < target) begin
				burst = ($urandom_range(0, 4) == 0);
				case ($urandom_range(0, 19))
					0:       len = 0;
					1:       len = $urandom_range(30, 60);
					default: len = $urandom_range(1, 12);
				endcase
				send_name(len, burst);
				if ($urandom_range(0, 29) == 0)
					drain_results();
			end
			drain_results();
		end

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("streamed %0d characters in %0d names, checked %0d slot results",
			sb.chars, sb.names, sb.checked);
		$display("index widths exercised: reset value plus %0d written settings",
			$size(widths));
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
